// File: rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants of the file sector allocator
// Result codes, default sizes, the result beat layout and the name trimming
// function used on request entry.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int MAP_ENTRIES_DEF      = 256;
  localparam int DIR_ENTRIES_DEF      = 16;
  localparam int SECTORS_PER_FILE_DEF = 20;
  localparam int NAME_BYTES_DEF       = 12;
  localparam int RESERVED_RESET       = 3;

  localparam int NAME_LOW_W  = 64;
  localparam int NAME_HIGH_W = 32;
  localparam int NAME_W      = NAME_LOW_W + NAME_HIGH_W;
  localparam int NAME_MAX    = NAME_W / 8;
  localparam int COUNT_W     = 5;
  localparam int CFG_W       = 9;
  localparam int ENTRY_W     = 4;
  localparam int SECTOR_W    = 8;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK           = 2'd0;
  localparam status_t STATUS_INSUFFICIENT = 2'd1;
  localparam status_t STATUS_NO_ENTRY     = 2'd2;

  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [ENTRY_W-1:0]  entry_index;
    logic [SECTOR_W-1:0] sector_number;
    logic                sector_valid;
    logic                last;
  } result_t;

  // Keeps the name bytes up to the first zero byte and below nbytes.
  function automatic logic [NAME_W-1:0] name_trim(input logic [NAME_LOW_W-1:0]  lo,
                                                  input logic [NAME_HIGH_W-1:0] hi,
                                                  input int                     nbytes);
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] trimmed;
    logic              alive;
    raw     = {hi, lo};
    trimmed = '0;
    alive   = 1'b1;
    for (int i = 0; i < NAME_MAX; i++) begin
      if (raw[8*i +: 8] == 8'h00 || i >= nbytes) begin
        alive = 1'b0;
      end
      if (alive) begin
        trimmed[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return trimmed;
  endfunction

endpackage

// File: rtl/file_sector_allocator_top.sv
// ----------------------------------------------------------------------------
// file_sector_allocator_top: file-create allocator with sector map and directory
// Takes a file-create request (name and sector count), finds the first free
// directory slot, checks and claims the lowest free map sectors and reports
// one result beat per claimed sector, or a single beat when none is claimed.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   -------   -----------------   ----------------------------------------------
//   request   start && !busy      name_low, name_high, sector_count
//   result    result_valid        status, entry_index, sector_number,
//                                 sector_valid, last
//   config    cfg_we              cfg_data (reserved sector count)
//
// After reset the block clears the sector map and the directory with busy held
// high. During a request busy stays high, and the directory scan and both map
// passes read one memory entry per cycle. Result beats last one cycle each and
// the receiver cannot stall them; busy falls in the cycle of the final beat, so
// the next request can be taken then.
// ----------------------------------------------------------------------------
module file_sector_allocator_top #(
  parameter int MAP_ENTRIES      = fsa_pkg::MAP_ENTRIES_DEF,
  parameter int DIR_ENTRIES      = fsa_pkg::DIR_ENTRIES_DEF,
  parameter int SECTORS_PER_FILE = fsa_pkg::SECTORS_PER_FILE_DEF,
  parameter int NAME_BYTES       = fsa_pkg::NAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [fsa_pkg::NAME_LOW_W-1:0]  name_low,
  input  logic [fsa_pkg::NAME_HIGH_W-1:0] name_high,
  input  logic [fsa_pkg::COUNT_W-1:0]     sector_count,
  input  logic                            cfg_we,
  input  logic [fsa_pkg::CFG_W-1:0]       cfg_data,
  output logic                            result_valid,
  output logic [1:0]                      status,
  output logic [fsa_pkg::ENTRY_W-1:0]     entry_index,
  output logic [fsa_pkg::SECTOR_W-1:0]    sector_number,
  output logic                            sector_valid,
  output logic                            last
);
  import fsa_pkg::*;

  localparam int MAP_AW = $clog2(MAP_ENTRIES);
  localparam int DIR_AW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

  result_t           res;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic              map_wdata;
  logic [MAP_AW-1:0] map_raddr;
  logic              map_q;
  logic              dir_we;
  logic [DIR_AW-1:0] dir_waddr;
  logic [NAME_W-1:0] dir_wdata;
  logic [DIR_AW-1:0] dir_raddr;
  logic [NAME_W-1:0] dir_q;

  // The sequencer owns every control register and the result beat register.
  fsa_ctrl #(
    .MAP_ENTRIES      (MAP_ENTRIES),
    .DIR_ENTRIES      (DIR_ENTRIES),
    .SECTORS_PER_FILE (SECTORS_PER_FILE),
    .NAME_BYTES       (NAME_BYTES),
    .MAP_AW           (MAP_AW),
    .DIR_AW           (DIR_AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .name_low     (name_low),
    .name_high    (name_high),
    .sector_count (sector_count),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .busy         (busy),
    .res          (res),
    .map_we       (map_we),
    .map_waddr    (map_waddr),
    .map_wdata    (map_wdata),
    .map_raddr    (map_raddr),
    .map_q        (map_q),
    .dir_we       (dir_we),
    .dir_waddr    (dir_waddr),
    .dir_wdata    (dir_wdata),
    .dir_raddr    (dir_raddr),
    .dir_q        (dir_q)
  );

  // Allocation map: one used bit per sector. Reserved sectors are not stored
  // here; the sequencer treats every sector below the reserved count as used.
  fsa_ram #(
    .WIDTH (1),
    .DEPTH (MAP_ENTRIES),
    .AW    (MAP_AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  // Directory: the trimmed name of each slot. A slot is free when its first
  // name byte is zero.
  fsa_ram #(
    .WIDTH (NAME_W),
    .DEPTH (DIR_ENTRIES),
    .AW    (DIR_AW)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_q)
  );

  assign result_valid  = res.valid;
  assign status        = res.status;
  assign entry_index   = res.entry_index;
  assign sector_number = res.sector_number;
  assign sector_valid  = res.sector_valid;
  assign last          = res.last;

`ifndef SYNTHESIS
  // A failure is always a single beat with no slot and no sector.
  a_fail_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |->
      last && !sector_valid && entry_index == '0 && sector_number == '0)
    else $error("failure beat carries slot or sector data");

  // Every beat of an allocation that is not the final one names a sector.
  a_mid_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == STATUS_OK && sector_valid)
    else $error("non-final beat without an allocated sector");

  // The final beat of a request coincides with the block going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("block still busy on the final beat");

  // An accepted request keeps the block busy for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !result_valid)
    else $error("accepted request did not make the block busy");
`endif

endmodule

// File: rtl/fsa_ram.sv
// ----------------------------------------------------------------------------
// fsa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fsa_ctrl.sv
// ----------------------------------------------------------------------------
// fsa_ctrl: request sequencer of the file sector allocator
// Clears both memories after reset, scans the directory for a free slot,
// counts free map sectors, stores the name and allocates sectors, emitting
// one result beat per allocated sector, or a single beat when none is allocated.
// ----------------------------------------------------------------------------
module fsa_ctrl #(
  parameter int MAP_ENTRIES      = 256,
  parameter int DIR_ENTRIES      = 16,
  parameter int SECTORS_PER_FILE = 20,
  parameter int NAME_BYTES       = 12,
  parameter int MAP_AW           = $clog2(MAP_ENTRIES),
  parameter int DIR_AW           = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fsa_pkg::NAME_LOW_W-1:0]  name_low,
  input  logic [fsa_pkg::NAME_HIGH_W-1:0] name_high,
  input  logic [fsa_pkg::COUNT_W-1:0]   sector_count,
  input  logic                          cfg_we,
  input  logic [fsa_pkg::CFG_W-1:0]     cfg_data,
  output logic                          busy,
  output fsa_pkg::result_t              res,
  output logic                          map_we,
  output logic [MAP_AW-1:0]             map_waddr,
  output logic                          map_wdata,
  output logic [MAP_AW-1:0]             map_raddr,
  input  logic                          map_q,
  output logic                          dir_we,
  output logic [DIR_AW-1:0]             dir_waddr,
  output logic [fsa_pkg::NAME_W-1:0]    dir_wdata,
  output logic [DIR_AW-1:0]             dir_raddr,
  input  logic [fsa_pkg::NAME_W-1:0]    dir_q
);
  import fsa_pkg::*;

  localparam int SCAN_W   = (MAP_AW > DIR_AW) ? MAP_AW : DIR_AW;
  localparam int CLR_LAST = ((MAP_ENTRIES > DIR_ENTRIES) ? MAP_ENTRIES : DIR_ENTRIES) - 1;
  localparam int RES_W    = $clog2(MAP_ENTRIES + 1);
  localparam int CNT_W    = $clog2(SECTORS_PER_FILE + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIR   = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_DWR   = 3'd4;
  localparam logic [2:0] S_ALLOC = 3'd5;

  logic [2:0]        state;
  logic [SCAN_W-1:0] iss_idx;
  logic              iss_more;
  logic              chk_v;
  logic [SCAN_W-1:0] chk_idx;
  logic [DIR_AW-1:0] slot;
  logic [COUNT_W-1:0] want;
  logic [NAME_W-1:0] name;
  logic [CNT_W-1:0]  cnt;
  logic [RES_W-1:0]  resv;

  logic [MAP_AW-1:0] chk_map;
  logic [DIR_AW-1:0] chk_dir;
  logic              map_free;
  logic [CNT_W:0]    cnt_inc;
  logic              hit;
  logic              map_end;
  logic              dir_end;
  logic [SCAN_W-1:0] scan_last;
  logic [RES_W-1:0]  cfg_clamp;
  logic [DIR_AW+3:0] slot_ext;
  logic [ENTRY_W-1:0] entry;
  logic              clr_map;
  logic              clr_dir;

  assign busy      = (state != S_IDLE);
  assign chk_map   = chk_idx[MAP_AW-1:0];
  assign chk_dir   = chk_idx[DIR_AW-1:0];
  assign map_free  = !map_q && (RES_W'(chk_map) >= resv);
  assign cnt_inc   = {1'b0, cnt} + 1'b1;
  assign hit       = chk_v && map_free && (cnt_inc == (CNT_W+1)'(want));
  assign map_end   = (chk_map == MAP_AW'(MAP_ENTRIES - 1));
  assign dir_end   = (chk_dir == DIR_AW'(DIR_ENTRIES - 1));
  assign scan_last = (state == S_DIR) ? SCAN_W'(DIR_ENTRIES - 1) : SCAN_W'(MAP_ENTRIES - 1);
  assign cfg_clamp = ({1'b0, cfg_data} > (CFG_W+1)'(MAP_ENTRIES)) ?
                     RES_W'(MAP_ENTRIES) : RES_W'(cfg_data);
  assign slot_ext  = {4'b0, slot};
  assign entry     = slot_ext[ENTRY_W-1:0];
  assign clr_map   = (state == S_CLEAR) && ({1'b0, iss_idx} < (SCAN_W+1)'(MAP_ENTRIES));
  assign clr_dir   = (state == S_CLEAR) && ({1'b0, iss_idx} < (SCAN_W+1)'(DIR_ENTRIES));

  // Memory ports
  assign map_raddr = iss_idx[MAP_AW-1:0];
  assign dir_raddr = iss_idx[DIR_AW-1:0];
  assign map_we    = clr_map || ((state == S_ALLOC) && chk_v && map_free);
  assign map_waddr = (state == S_CLEAR) ? iss_idx[MAP_AW-1:0] : chk_map;
  assign map_wdata = (state == S_ALLOC);
  assign dir_we    = clr_dir || (state == S_DWR);
  assign dir_waddr = (state == S_DWR) ? slot : iss_idx[DIR_AW-1:0];
  assign dir_wdata = (state == S_DWR) ? name : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      iss_idx  <= '0;
      iss_more <= 1'b0;
      chk_v    <= 1'b0;
      resv     <= RES_W'(RESERVED_RESET);
      res      <= '0;
    end else begin
      res <= '0;
      if (cfg_we && (cfg_clamp > resv)) begin
        resv <= cfg_clamp;
      end
      // Shared read issue for the three scan states.
      if (state == S_DIR || state == S_COUNT || state == S_ALLOC) begin
        chk_v   <= iss_more;
        chk_idx <= iss_idx;
        if (iss_idx == scan_last) begin
          iss_more <= 1'b0;
        end else begin
          iss_idx <= iss_idx + 1'b1;
        end
      end
      unique case (state)
        S_CLEAR: begin
          if (iss_idx == SCAN_W'(CLR_LAST)) begin
            state <= S_IDLE;
          end else begin
            iss_idx <= iss_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            name     <= name_trim(name_low, name_high, NAME_BYTES);
            want     <= sector_count;
            iss_idx  <= '0;
            iss_more <= 1'b1;
            chk_v    <= 1'b0;
            state    <= S_DIR;
          end
        end
        S_DIR: begin
          if (chk_v) begin
            if (dir_q[7:0] == 8'h00) begin
              slot     <= chk_dir;
              iss_idx  <= '0;
              iss_more <= 1'b1;
              chk_v    <= 1'b0;
              cnt      <= '0;
              if ({1'b0, want} > (COUNT_W+1)'(SECTORS_PER_FILE)) begin
                res.valid  <= 1'b1;
                res.status <= STATUS_INSUFFICIENT;
                res.last   <= 1'b1;
                state      <= S_IDLE;
              end else if (want == '0) begin
                state <= S_DWR;
              end else begin
                state <= S_COUNT;
              end
            end else if (dir_end) begin
              res.valid  <= 1'b1;
              res.status <= STATUS_NO_ENTRY;
              res.last   <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        S_COUNT: begin
          if (chk_v && map_free) begin
            cnt <= cnt_inc[CNT_W-1:0];
          end
          if (hit) begin
            state <= S_DWR;
          end else if (chk_v && map_end) begin
            res.valid  <= 1'b1;
            res.status <= STATUS_INSUFFICIENT;
            res.last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DWR: begin
          cnt      <= '0;
          iss_idx  <= '0;
          iss_more <= 1'b1;
          chk_v    <= 1'b0;
          if (want == '0) begin
            res.valid       <= 1'b1;
            res.status      <= STATUS_OK;
            res.entry_index <= entry;
            res.last        <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (chk_v && map_free) begin
            res.valid         <= 1'b1;
            res.status        <= STATUS_OK;
            res.entry_index   <= entry;
            res.sector_number <= SECTOR_W'(chk_map);
            res.sector_valid  <= 1'b1;
            res.last          <= hit;
            cnt               <= cnt_inc[CNT_W-1:0];
          end
          if (hit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for file_sector_allocator_top
// Drives file-create requests through the start/busy handshake, predicts
// every result beat from a private copy of the sector map and the directory,
// and compares each beat field by field as it goes by. A short table of
// directed requests comes first. Random phases follow that spend the map,
// fill the directory and change the reserved-sector count between phases.
// ----------------------------------------------------------------------------
module testbench;
  import fsa_pkg::*;

  localparam int MAP_N       = MAP_ENTRIES_DEF;
  localparam int DIR_N       = DIR_ENTRIES_DEF;
  localparam int PER_FILE    = SECTORS_PER_FILE_DEF;
  localparam int NAME_N      = NAME_BYTES_DEF;
  // The slowest request scans the directory and walks the map twice.
  localparam int TAIL_CYCLES = 2 * MAP_N + DIR_N + 64;
  // Longest quiet stretch: sender gap, clearing pass and a full request,
  // taken many times over.
  localparam int QUIET_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  // One result beat as the bench sees it.
  typedef struct packed {
    status_t             status;
    logic [ENTRY_W-1:0]  entry;
    logic [SECTOR_W-1:0] sector;
    logic                sector_ok;
    logic                last;
  } beat_t;

  // A row of the directed table. Rows marked FIXED carry their single
  // expected beat; CALC rows are worked out by the predictor.
  localparam bit CALC  = 1'b0;
  localparam bit FIXED = 1'b1;

  typedef struct packed {
    logic [NAME_LOW_W-1:0]  lo;
    logic [NAME_HIGH_W-1:0] hi;
    logic [COUNT_W-1:0]     cnt;
    bit                     typed;
    beat_t                  beat;
  } plan_row_t;

  typedef enum int {PH_MIX, PH_SPEND, PH_FILL} phase_t;

  localparam int PLAN_ROWS = 12;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Empty name, zero count: slot 0 reported, but it stays free.
    '{64'h0, 32'h0, 5'd0, FIXED, '{STATUS_OK, 4'd0, 8'd0, 1'b0, 1'b1}},
    // Empty name with junk in the high bytes takes the first free sector.
    '{64'h0, 32'hFFFF_FFFF, 5'd1, FIXED, '{STATUS_OK, 4'd0, 8'd3, 1'b1, 1'b1}},
    // Counts above the per-file limit are refused even with plenty free.
    '{64'h41, 32'h0, 5'd31, FIXED, '{STATUS_INSUFFICIENT, 4'd0, 8'd0, 1'b0, 1'b1}},
    '{64'h42, 32'h0, 5'd21, FIXED, '{STATUS_INSUFFICIENT, 4'd0, 8'd0, 1'b0, 1'b1}},
    // Full twelve-byte name of all ones at the largest legal count.
    '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5'd20, CALC, '0},
    // A zero byte in the middle cuts the name short.
    '{64'h4847_4600_4443_4241, 32'h0, 5'd2, CALC, '0},
    // Zero byte inside the high word, zero count stores the name only.
    '{64'h0102_0304_0506_0708, 32'h1100_0009, 5'd0, CALC, '0},
    '{64'h00FF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5'd3, CALC, '0},
    '{64'h8000_0000_0000_0001, 32'h8000_0000, 5'd1, CALC, '0},
    '{64'h5A, 32'h0, 5'd16, CALC, '0},
    '{64'h0, 32'h0, 5'd15, CALC, '0},
    '{64'h7E, 32'h0, 5'd0, CALC, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [NAME_LOW_W-1:0]  name_low;
  logic [NAME_HIGH_W-1:0] name_high;
  logic [COUNT_W-1:0]     sector_count;
  logic                   cfg_we;
  logic [CFG_W-1:0]       cfg_data;
  logic                   result_valid;
  logic [1:0]             status;
  logic [ENTRY_W-1:0]     entry_index;
  logic [SECTOR_W-1:0]    sector_number;
  logic                   sector_valid;
  logic                   last;

  file_sector_allocator_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .name_low      (name_low),
    .name_high     (name_high),
    .sector_count  (sector_count),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .status        (status),
    .entry_index   (entry_index),
    .sector_number (sector_number),
    .sector_valid  (sector_valid),
    .last          (last)
  );

  always #1 clk = ~clk;

  // Private copy of the allocator state, kept in step with every accepted
  // request and every register write.
  bit                     map_used [MAP_N];
  logic [NAME_LOW_W-1:0]  dir_low  [DIR_N];
  logic [NAME_HIGH_W-1:0] dir_high [DIR_N];
  logic [SECTOR_W-1:0]    dir_list [DIR_N][PER_FILE];

  beat_t pending_beats [$];

  int errors;
  int requests_sent;
  int cfg_writes;
  int beats_ok;
  int beats_short;
  int beats_full_dir;
  int burst_left;
  int quiet_cycles;

  // Marks the lowest sectors as used; counts past the map end saturate.
  function automatic void reserve_low(input int count);
    int i;
    if (count > MAP_N) begin
      count = MAP_N;
    end
    for (i = 0; i < count; i++) begin
      map_used[i] = 1'b1;
    end
  endfunction

  function automatic void clear_state();
    int s;
    int k;
    for (s = 0; s < MAP_N; s++) begin
      map_used[s] = 1'b0;
    end
    for (s = 0; s < DIR_N; s++) begin
      dir_low[s]  = '0;
      dir_high[s] = '0;
      for (k = 0; k < PER_FILE; k++) begin
        dir_list[s][k] = '0;
      end
    end
    reserve_low(RESERVED_RESET);
  endfunction

  function automatic void queue_beat(input status_t st, input int slot, input int sec,
                                     input bit ok, input bit fin);
    beat_t b;
    b.status    = st;
    b.entry     = slot[ENTRY_W-1:0];
    b.sector    = sec[SECTOR_W-1:0];
    b.sector_ok = ok;
    b.last      = fin;
    pending_beats.push_back(b);
  endfunction

  function automatic int free_slots();
    int s;
    int n;
    n = 0;
    for (s = 0; s < DIR_N; s++) begin
      if (dir_low[s][7:0] == 8'h00) begin
        n++;
      end
    end
    return n;
  endfunction

  // Works out the beats of one file-create request, updates the private
  // state and returns how many beats were queued.
  function automatic int predict_create(input logic [NAME_LOW_W-1:0]  lo,
                                        input logic [NAME_HIGH_W-1:0] hi,
                                        input logic [COUNT_W-1:0]     cnt);
    int slot;
    int free_n;
    int i;
    int k;
    bit alive;
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] kept;
    slot = -1;
    for (i = 0; i < DIR_N; i++) begin
      if (slot < 0 && dir_low[i][7:0] == 8'h00) begin
        slot = i;
      end
    end
    if (slot < 0) begin
      queue_beat(STATUS_NO_ENTRY, 0, 0, 1'b0, 1'b1);
      return 1;
    end
    free_n = 0;
    for (i = 0; i < MAP_N; i++) begin
      if (!map_used[i]) begin
        free_n++;
      end
    end
    if (cnt > PER_FILE || free_n < cnt) begin
      queue_beat(STATUS_INSUFFICIENT, 0, 0, 1'b0, 1'b1);
      return 1;
    end
    // Keep name bytes up to the first zero byte.
    raw   = {hi, lo};
    kept  = '0;
    alive = 1'b1;
    for (i = 0; i < NAME_N; i++) begin
      if (raw[8*i +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        kept[8*i +: 8] = raw[8*i +: 8];
      end
    end
    dir_low[slot]  = kept[NAME_LOW_W-1:0];
    dir_high[slot] = kept[NAME_W-1:NAME_LOW_W];
    for (i = 0; i < PER_FILE; i++) begin
      dir_list[slot][i] = '0;
    end
    if (cnt == 0) begin
      queue_beat(STATUS_OK, slot, 0, 1'b0, 1'b1);
      return 1;
    end
    k = 0;
    for (i = 0; i < MAP_N; i++) begin
      if (k < cnt && !map_used[i]) begin
        map_used[i]    = 1'b1;
        dir_list[slot][k] = i[SECTOR_W-1:0];
        queue_beat(STATUS_OK, slot, i, 1'b1, (k + 1 == cnt));
        k++;
      end
    end
    return k;
  endfunction

  // Random name; empty ones have a zero first byte, others may still carry
  // a zero byte further in.
  function automatic void pick_name(input bit empty, output logic [NAME_LOW_W-1:0] lo,
                                    output logic [NAME_HIGH_W-1:0] hi);
    int cut;
    lo = {$urandom, $urandom};
    hi = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      cut = $urandom_range(1, NAME_N - 1);
      if (cut < 8) begin
        lo[8*cut +: 8] = 8'h00;
      end else begin
        hi[8*(cut-8) +: 8] = 8'h00;
      end
    end
    if (empty) begin
      lo[7:0] = 8'h00;
    end else if (lo[7:0] == 8'h00) begin
      lo[7:0] = 8'($urandom_range(1, 255));
    end
  endfunction

  // Mostly small counts so the map lasts, with some large and oversized ones.
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return COUNT_W'($urandom_range(0, 1));
    end else if (r < 85) begin
      return COUNT_W'($urandom_range(2, 4));
    end else if (r < 95) begin
      return COUNT_W'($urandom_range(5, PER_FILE));
    end
    return COUNT_W'($urandom_range(PER_FILE + 1, 31));
  endfunction

  // Presents one request and holds it until the block takes it. The sender
  // works in bursts; between bursts start drops for a random gap, sometimes
  // long enough to land in any part of a request's processing.
  task automatic send_request(input logic [NAME_LOW_W-1:0]  lo,
                              input logic [NAME_HIGH_W-1:0] hi,
                              input logic [COUNT_W-1:0]     cnt,
                              input bit                     typed,
                              input beat_t                  typed_beat);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    start        <= 1'b1;
    name_low     <= lo;
    name_high    <= hi;
    sector_count <= cnt;
    burst_left--;
    do @(posedge clk); while (busy);
    // Taken at this edge. The predictor always runs so the state stays in
    // step; a table row with a typed beat replaces what it queued.
    n = predict_create(lo, hi, cnt);
    if (typed) begin
      repeat (n) void'(pending_beats.pop_back());
      pending_beats.push_back(typed_beat);
    end
    requests_sent++;
  endtask

  // The register is only written with the block idle: start is dropped, all
  // outstanding beats are awaited, a short pause covers the final busy
  // cycle, and busy must be low.
  task automatic write_reserved(input logic [CFG_W-1:0] value);
    start      <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reserve_low(value);
    cfg_writes++;
  endtask

  // Random requests. The mixed phase keeps a few directory slots open so the
  // map can be spent first; the spend phase uses empty names and big counts
  // to run the map dry; the fill phase uses real names to fill the directory.
  task automatic run_phase(input int n, input phase_t mode);
    int i;
    bit empty;
    logic [NAME_LOW_W-1:0]  lo;
    logic [NAME_HIGH_W-1:0] hi;
    logic [COUNT_W-1:0]     cnt;
    for (i = 0; i < n; i++) begin
      case (mode)
        PH_SPEND: begin
          empty = 1'b1;
          cnt   = ($urandom_range(0, 5) == 0) ? COUNT_W'($urandom_range(PER_FILE + 1, 31))
                                              : COUNT_W'($urandom_range(1, PER_FILE));
        end
        PH_FILL: begin
          empty = 1'b0;
          cnt   = COUNT_W'($urandom_range(0, 3));
        end
        default: begin
          empty = !(free_slots() > 4 && $urandom_range(0, 99) < 15);
          cnt   = pick_count();
        end
      endcase
      pick_name(empty, lo, hi);
      send_request(lo, hi, cnt, CALC, '0);
    end
  endtask

  // Result checker. Every beat lives for one cycle only, so it is sampled at
  // the edge that ends that cycle and matched against the oldest prediction.
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && result_valid) begin
      got = {status, entry_index, sector_number, sector_valid, last};
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected beat: status %0d entry %0d sector %0d valid %0b last %0b",
                   got.status, got.entry, got.sector, got.sector_ok, got.last);
        end
      end else begin
        want = pending_beats.pop_front();
        case (want.status)
          STATUS_OK:           beats_ok++;
          STATUS_INSUFFICIENT: beats_short++;
          default:             beats_full_dir++;
        endcase
        if (got.status !== want.status || got.entry !== want.entry ||
            got.sector !== want.sector || got.sector_ok !== want.sector_ok ||
            got.last !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("beat mismatch: want st %0d ent %0d sec %0d v %0b l %0b,",
                     want.status, want.entry, want.sector, want.sector_ok, want.last);
            $display("               got st %0d ent %0d sec %0d v %0b l %0b",
                     got.status, got.entry, got.sector, got.sector_ok, got.last);
          end
        end
      end
    end
  end

  // Watchdog: any accepted request, result beat or register write counts as
  // progress; a long stretch without any ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d beats outstanding", pending_beats.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    plan_row_t row;
    rst            = 1'b1;
    start          = 1'b0;
    name_low       = '0;
    name_high      = '0;
    sector_count   = '0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    errors         = 0;
    requests_sent  = 0;
    cfg_writes     = 0;
    beats_ok       = 0;
    beats_short    = 0;
    beats_full_dir = 0;
    burst_left     = 0;
    quiet_cycles   = 0;
    clear_state();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // The block clears its map and directory after reset; wait it out.
    @(posedge clk);
    while (busy) @(posedge clk);

    // Lowest setting first: it adds nothing to the reset reservation.
    write_reserved(9'd0);
    for (i = 0; i < PLAN_ROWS; i++) begin
      row = PLAN[i];
      send_request(row.lo, row.hi, row.cnt, row.typed, row.beat);
    end

    write_reserved(9'd70);
    run_phase(55, PH_MIX);
    write_reserved(9'd150);
    run_phase(55, PH_MIX);
    run_phase(15, PH_SPEND);
    run_phase(20, PH_FILL);
    // Top of the range, then the largest encodable value, which saturates.
    write_reserved(9'd256);
    run_phase(4, PH_MIX);
    write_reserved(9'd511);
    run_phase(6, PH_MIX);

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d register writes", requests_sent, cfg_writes);
    $display("beats: %0d allocated, %0d short of sectors, %0d directory full, %0d errors",
             beats_ok, beats_short, beats_full_dir, errors);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
